// File: design/spq_pkg.sv
// Package for the sorted priority queue: capacity, widths, operation and
// status codes, and the packed types of the request, result and cell entry.
// Depends on nothing; every other design file uses it by scoped names.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int COUNT_W  = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_PEEK   = 2'd2
	} op_code_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_FULL      = 2'd2
	} status_code_t;

	typedef struct packed {
		logic [1:0]          operation;
		logic signed [15:0]  priority_req;
		logic signed [31:0]  item;
	} request_t;

	typedef struct packed {
		logic [1:0]          status;
		logic                empty_res;
		logic [COUNT_W-1:0]  count;
		logic signed [15:0]  max_priority;
		logic signed [31:0]  max_item;
		logic signed [15:0]  min_priority;
		logic signed [31:0]  min_item;
	} result_t;

	typedef struct packed {
		logic signed [15:0]  prio;
		logic signed [31:0]  item;
	} entry_t;

	// Control that the top level hands to each cell of the chain.
	typedef struct packed {
		logic ins;      // an insert is accepted this cycle
		logic valid;    // this cell holds a live entry
		logic left_lt;  // left neighbor keeps its entry (tied high at the head)
	} cell_ctrl_t;

endpackage

// File: design/spq_cell.sv
// One cell of the sorted chain: holds one entry, compares it with the entry
// being inserted and either keeps it, takes the new entry or takes its left
// neighbor's entry. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  spq_pkg::entry_t    new_entry,
	input  spq_pkg::entry_t    left_entry,
	output spq_pkg::entry_t    entry,
	output logic               lt
);

	spq_pkg::entry_t entry_q;

	// Strictly less keeps the entry in place, so an equal priority lands in
	// front of the older entries with the same priority.
	assign lt    = ctrl.valid && (entry_q.prio < new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt) begin
			entry_q <= ctrl.left_lt ? new_entry : left_entry;
		end
	end

endmodule

// File: design/sorted_priority_queue.sv
// Sorted priority queue built as a chain of spq_pkg::CAPACITY cells.
// The result strobe follows the accepting edge through two registers, pending_s1 and done_q.
// Throughput: one transaction per cycle; busy stays low, since every cell
// compares and shifts in the cycle of the insert and a remove only moves the count.
// Reset clears the entry count and the result strobe; cell contents are left as they are.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module sorted_priority_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  spq_pkg::request_t  request,
	output logic               done,
	output spq_pkg::result_t   result
);

	localparam int CAP = spq_pkg::CAPACITY;

	logic [spq_pkg::CNT_W-1:0] count_q;
	logic                      accept;
	logic                      is_full;
	logic                      is_empty;
	logic                      do_insert;
	logic                      do_remove;
	logic [1:0]                status_d;

	spq_pkg::entry_t           new_entry;
	spq_pkg::entry_t           cell_entry [CAP];
	logic [CAP-1:0]            cell_lt;

	logic                      pending_s1;
	logic [1:0]                status_s1;
	logic                      done_q;
	spq_pkg::result_t          result_q;
	spq_pkg::entry_t           tail_entry;

	assign busy      = 1'b0;
	assign accept    = start && !busy;
	assign is_full   = (count_q >= spq_pkg::CNT_W'(CAP));
	assign is_empty  = (count_q == '0);
	assign do_insert = accept && (request.operation == spq_pkg::OP_INSERT) && !is_full;
	assign do_remove = accept && (request.operation == spq_pkg::OP_REMOVE) && !is_empty;

	assign new_entry.prio = request.priority_req;
	assign new_entry.item = request.item;

	always_comb begin
		status_d = spq_pkg::ST_OK;
		case (request.operation)
			spq_pkg::OP_INSERT: begin
				if (is_full) status_d = spq_pkg::ST_FULL;
			end
			spq_pkg::OP_REMOVE: begin
				if (is_empty) status_d = spq_pkg::ST_UNDERFLOW;
			end
			default: status_d = spq_pkg::ST_OK;
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAP; gi++) begin : g_cell
			spq_pkg::cell_ctrl_t ctrl;
			spq_pkg::entry_t     left_entry;

			assign ctrl.ins   = do_insert;
			assign ctrl.valid = (count_q > spq_pkg::CNT_W'(gi));
			if (gi == 0) begin : g_head
				assign ctrl.left_lt = 1'b1;
				assign left_entry   = new_entry;
			end else begin : g_body
				assign ctrl.left_lt = cell_lt[gi-1];
				assign left_entry   = cell_entry[gi-1];
			end

			spq_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.new_entry  (new_entry),
				.left_entry (left_entry),
				.entry      (cell_entry[gi]),
				.lt         (cell_lt[gi])
			);
		end
	endgenerate

	// The tail is read only when the queue is not empty.
	assign tail_entry = cell_entry[spq_pkg::IDX_W'(count_q - 1'b1)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			pending_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (do_insert) begin
				count_q <= count_q + 1'b1;
			end else if (do_remove) begin
				count_q <= count_q - 1'b1;
			end
			pending_s1 <= accept;
			done_q     <= pending_s1;
		end
	end

	// The second stage sees the chain after the transaction has settled in it.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
		end
		if (pending_s1) begin
			result_q.status    <= status_s1;
			result_q.empty_res <= is_empty;
			result_q.count     <= spq_pkg::COUNT_W'(count_q);
			if (is_empty) begin
				result_q.max_priority <= '0;
				result_q.max_item     <= '0;
				result_q.min_priority <= '0;
				result_q.min_item     <= '0;
			end else begin
				result_q.max_priority <= tail_entry.prio;
				result_q.max_item     <= tail_entry.item;
				result_q.min_priority <= cell_entry[0].prio;
				result_q.min_item     <= cell_entry[0].item;
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::CNT_W'(CAP))
		else $error("entry count exceeds capacity");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("result strobe missing two cycles after a transaction");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == spq_pkg::ST_FULL) |-> result.count == spq_pkg::COUNT_W'(CAP))
		else $error("full status reported below capacity");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= spq_pkg::CNT_W'(2)) |-> (cell_entry[0].prio <= cell_entry[1].prio))
		else $error("head entries out of order");

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the sorted priority queue: directed corner cases, then
// random insert/remove/peek/spare-code traffic with random start gaps.
// Depends on spq_pkg and sorted_priority_queue from the design folder.
`timescale 1ns / 1ps

// Keeps a sorted copy of the queue contents and the results still owed by the block.
class queue_scoreboard;
	logic signed [15:0] held_prio[$];
	logic signed [31:0] held_item[$];
	spq_pkg::result_t owed[$];
	int unsigned failures;

	function new();
		failures = 0;
	endfunction

	function void note_request(spq_pkg::request_t req);
		spq_pkg::result_t res;
		int pos;
		res = '0;
		res.status = spq_pkg::ST_OK;
		if (req.operation == spq_pkg::OP_INSERT) begin
			if (held_prio.size() >= spq_pkg::CAPACITY) begin
				res.status = spq_pkg::ST_FULL;
			end else begin
				// The new entry goes ahead of every entry with greater or equal priority.
				pos = 0;
				while (pos < held_prio.size() &&
				       $signed(held_prio[pos]) < $signed(req.priority_req))
					pos++;
				held_prio.insert(pos, req.priority_req);
				held_item.insert(pos, req.item);
			end
		end else if (req.operation == spq_pkg::OP_REMOVE) begin
			if (held_prio.size() == 0) begin
				res.status = spq_pkg::ST_UNDERFLOW;
			end else begin
				held_prio.delete(held_prio.size() - 1);
				held_item.delete(held_item.size() - 1);
			end
		end
		res.count     = spq_pkg::COUNT_W'(held_prio.size());
		res.empty_res = (held_prio.size() == 0);
		if (held_prio.size() != 0) begin
			res.max_priority = held_prio[held_prio.size() - 1];
			res.max_item     = held_item[held_item.size() - 1];
			res.min_priority = held_prio[0];
			res.min_item     = held_item[0];
		end
		owed.push_back(res);
	endfunction

	function void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			failures++;
		end
	endfunction

	function void check_result(spq_pkg::result_t got);
		spq_pkg::result_t want;
		if (owed.size() == 0) begin
			$error("result strobe with no transaction outstanding");
			failures++;
			return;
		end
		want = owed.pop_front();
		compare_field("status", 32'(want.status), 32'(got.status));
		compare_field("empty_res", 32'(want.empty_res), 32'(got.empty_res));
		compare_field("count", 32'(want.count), 32'(got.count));
		compare_field("max_priority", 32'(want.max_priority), 32'(got.max_priority));
		compare_field("max_item", want.max_item, got.max_item);
		compare_field("min_priority", 32'(want.min_priority), 32'(got.min_priority));
		compare_field("min_item", want.min_item, got.min_item);
	endfunction
endclass

module tb_top;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 550;

	typedef enum int {TREND_FILL, TREND_DRAIN, TREND_MIXED} trend_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               done;
	spq_pkg::request_t  request;
	spq_pkg::result_t   result;

	queue_scoreboard sb;
	int unsigned cycles = 0;

	sorted_priority_queue dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	function automatic spq_pkg::request_t make_request(logic [1:0] op,
	                                                   logic [15:0] prio,
	                                                   logic [31:0] data);
		spq_pkg::request_t req;
		req.operation    = op;
		req.priority_req = prio;
		req.item         = data;
		return req;
	endfunction

	// Mostly back-to-back, some short gaps, a few long ones.
	function automatic int unsigned pick_gap(bit burst);
		int unsigned w;
		if (burst)
			return 0;
		w = $urandom_range(9);
		if (w < 6)
			return 0;
		else if (w < 9)
			return $urandom_range(3, 1);
		return $urandom_range(20, 5);
	endfunction

	function automatic spq_pkg::request_t random_request(trend_t trend);
		int unsigned w;
		int unsigned ins_w;
		int unsigned rem_w;
		int near;
		logic [1:0] op;
		logic [15:0] prio;
		case (trend)
			TREND_FILL: begin
				ins_w = 70;
				rem_w = 15;
			end
			TREND_DRAIN: begin
				ins_w = 20;
				rem_w = 65;
			end
			default: begin
				ins_w = 45;
				rem_w = 40;
			end
		endcase
		w = $urandom_range(99);
		if (w < ins_w)
			op = spq_pkg::OP_INSERT;
		else if (w < ins_w + rem_w)
			op = spq_pkg::OP_REMOVE;
		else if (w < 95)
			op = spq_pkg::OP_PEEK;
		else
			op = OP_SPARE;
		// A narrow band of priorities produces plenty of ties.
		w = $urandom_range(9);
		if (w < 5) begin
			near = int'($urandom_range(6)) - 3;
			prio = near[15:0];
		end else if (w == 5) begin
			prio = $urandom_range(1) ? 16'h7FFF : 16'h8000;
		end else begin
			prio = 16'($urandom);
		end
		return make_request(op, prio, $urandom);
	endfunction

	task automatic send_request(input spq_pkg::request_t req, input int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(req);
	endtask

	initial begin
		trend_t trend;
		bit burst;
		sb = new();
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Operations on an empty queue, including the unused code.
		send_request(make_request(spq_pkg::OP_PEEK, 16'hFFFF, 32'hFFFF_FFFF), pick_gap(1'b0));
		send_request(make_request(spq_pkg::OP_REMOVE, 16'h0000, 32'h0000_0000), pick_gap(1'b0));
		send_request(make_request(OP_SPARE, 16'h1234, 32'hDEAD_BEEF), pick_gap(1'b0));
		// Extreme priorities and items, then ties at the head and at the tail.
		send_request(make_request(spq_pkg::OP_INSERT, 16'h0000, 32'h0000_0000), pick_gap(1'b0));
		send_request(make_request(spq_pkg::OP_INSERT, 16'h7FFF, 32'hFFFF_FFFF), pick_gap(1'b0));
		send_request(make_request(spq_pkg::OP_INSERT, 16'h8000, 32'h8000_0000), pick_gap(1'b0));
		send_request(make_request(spq_pkg::OP_INSERT, 16'h8000, 32'h7FFF_FFFF), pick_gap(1'b0));
		send_request(make_request(spq_pkg::OP_INSERT, 16'h7FFF, 32'h1234_5678), pick_gap(1'b0));
		send_request(make_request(spq_pkg::OP_PEEK, 16'h0000, 32'h0000_0000), pick_gap(1'b0));
		send_request(make_request(spq_pkg::OP_REMOVE, 16'h0000, 32'h0000_0000), pick_gap(1'b0));
		send_request(make_request(OP_SPARE, 16'h0000, 32'h0000_0000), pick_gap(1'b0));
		// Four entries remain; twelve more fill the queue, then one more is refused.
		repeat (12)
			send_request(make_request(spq_pkg::OP_INSERT, 16'($urandom), $urandom),
			             pick_gap(1'b0));
		send_request(make_request(spq_pkg::OP_INSERT, 16'h0001, 32'h5555_5555), pick_gap(1'b0));
		send_request(make_request(spq_pkg::OP_PEEK, 16'h0000, 32'h0000_0000), pick_gap(1'b0));

		trend = TREND_DRAIN;
		burst = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// Swing between filling and draining so full and empty are both hit often.
			if (i % 40 == 0) begin
				trend = trend_t'($urandom_range(2));
				burst = ($urandom_range(3) == 0);
			end
			send_request(random_request(trend), pick_gap(burst));
		end
		start <= 1'b0;

		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.owed.size() != 0) begin
			$error("%0d results never arrived", sb.owed.size());
			sb.failures++;
		end

		if (sb.failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
